[src/interval_set_insert_merge_unit_macros.svh]
// Assertion macros shared by the interval set insert and merge unit.
`ifndef INTERVAL_SET_INSERT_MERGE_UNIT_MACROS_SVH
`define INTERVAL_SET_INSERT_MERGE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, reported by label.
`define ISIM_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");
// Next-cycle implication, reported by label.
`define ISIM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");
`else
`define ISIM_ASSERT_IMPL(name, clk, rst, ante, cons)
`define ISIM_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

[src/isim_pkg.sv]
// Shared types, constants and helpers of the interval set insert and merge unit.
package isim_pkg;

   localparam int DEF_NUM_RULES  = 16;
   localparam int DEF_MAX_RANGES = 16;
   localparam int BAR_BITS       = 12;
   localparam int IDX_IN_W       = 4;
   localparam int WEIGHT_W       = 16;
   localparam int HAND_W         = 2;
   localparam int STATUS_W       = 3;
   localparam int COUNT_OUT_W    = 5;

   typedef enum logic [STATUS_W-1:0] {
      ST_CREATED  = 3'd0,
      ST_MERGED   = 3'd1,
      ST_ORDER    = 3'd2,
      ST_MISMATCH = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_META,
      S_SCAN,
      S_CHECK,
      S_MOVE,
      S_PLACE
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ram_ctl_type;

   function automatic int addr_bits(input int depth);
      return (depth > 1) ? $clog2(depth) : 1;
   endfunction

endpackage

[src/isim_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
module isim_ram
   import isim_pkg::*;
#(
   parameter int DEPTH = DEF_NUM_RULES,
   parameter int WIDTH = 2 * BAR_BITS,
   localparam int AW = addr_bits(DEPTH)
) (
   input  logic             clock,
   input  ram_ctl_type      ctl,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/isim_seq.sv]
// Sequencer: request decode, range scan and merge, list shift and result register.
module isim_seq
   import isim_pkg::*;
#(
   parameter int NUM_RULES  = DEF_NUM_RULES,
   parameter int MAX_RANGES = DEF_MAX_RANGES,
   localparam int IDX_W   = addr_bits(NUM_RULES),
   localparam int CNT_W   = $clog2(MAX_RANGES + 1),
   localparam int META_W  = WEIGHT_W + HAND_W + CNT_W,
   localparam int RADDR_W = addr_bits(NUM_RULES * MAX_RANGES),
   localparam int RANGE_W = 2 * BAR_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [IDX_IN_W-1:0]    req_rule_index,
   input  logic [BAR_BITS-1:0]    req_start_bar,
   input  logic [BAR_BITS-1:0]    req_end_bar,
   input  logic [WEIGHT_W-1:0]    req_rule_weight,
   input  logic [HAND_W-1:0]      req_hand_kind,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [COUNT_OUT_W-1:0] rsp_range_count,
   output logic [BAR_BITS-1:0]    rsp_merged_start,
   output logic [BAR_BITS-1:0]    rsp_merged_end,
   output ram_ctl_type            meta_ctl,
   output logic [IDX_W-1:0]       meta_wr_addr,
   output logic [IDX_W-1:0]       meta_rd_addr,
   output logic [META_W-1:0]      meta_wdata,
   input  logic [META_W-1:0]      meta_rdata,
   output ram_ctl_type            range_ctl,
   output logic [RADDR_W-1:0]     range_wr_addr,
   output logic [RADDR_W-1:0]     range_rd_addr,
   output logic [RANGE_W-1:0]     range_wdata,
   input  logic [RANGE_W-1:0]     range_rdata
);

   logic [IDX_W+IDX_IN_W-1:0] req_idx_ext;
   logic                      req_fire;
   logic                      out_free;

   state_type               state_ff, state_in;
   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic                    in_range_ff, in_range_in;
   logic [BAR_BITS-1:0]     s_ff, s_in, e_ff, e_in;
   logic [WEIGHT_W-1:0]     w_ff, w_in;
   logic [HAND_W-1:0]       h_ff, h_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [CNT_W-1:0]        p_ff, p_in;
   logic [CNT_W-1:0]        ptr_ff, ptr_in;
   logic [CNT_W-1:0]        src_ff, src_in;
   logic                    rd_vld_ff, rd_vld_in;
   logic [NUM_RULES-1:0]    valid_ff, valid_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic [BAR_BITS-1:0]     rsp_start_ff, rsp_start_in;
   logic [BAR_BITS-1:0]     rsp_end_ff, rsp_end_in;

   logic                    rule_vld;
   logic                    param_diff;
   logic [WEIGHT_W-1:0]     meta_w;
   logic [HAND_W-1:0]       meta_h;
   logic [CNT_W-1:0]        meta_cnt;
   logic [CNT_W-1:0]        cur_cnt;
   logic [CNT_W-1:0]        new_cnt;
   logic [BAR_BITS-1:0]     rd_s, rd_e;
   logic                    rd_ovl;
   logic                    move_dn;
   logic                    list_full;
   logic                    issue;
   logic                    emit, emit_go;
   logic                    set_valid;
   status_type              emit_status;
   logic [CNT_W-1:0]        emit_cnt;
   logic [BAR_BITS-1:0]     emit_s, emit_e;
   logic [CNT_W-1:0]        rd_slot, wr_slot;
   logic [RADDR_W-1:0]      rule_base;

   assign req_ready   = (state_ff == S_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign req_idx_ext = (IDX_W + IDX_IN_W)'(req_rule_index);

   assign meta_w     = meta_rdata[META_W-1 -: WEIGHT_W];
   assign meta_h     = meta_rdata[CNT_W +: HAND_W];
   assign meta_cnt   = meta_rdata[CNT_W-1:0];
   assign rule_vld   = valid_ff[idx_ff];
   assign cur_cnt    = rule_vld ? meta_cnt : '0;
   assign param_diff = (meta_w != w_ff) || (meta_h != h_ff);
   assign new_cnt    = cnt_ff - k_ff + CNT_W'(1);

   assign rd_s    = range_rdata[RANGE_W-1 -: BAR_BITS];
   assign rd_e    = range_rdata[BAR_BITS-1:0];
   assign rd_ovl  = (rd_e >= s_ff) && (rd_s <= e_ff);
   // No stored range absorbed: open a slot by shifting the tail up.
   assign move_dn   = (k_ff == '0);
   assign list_full = move_dn && (cnt_ff == CNT_W'(MAX_RANGES));

   assign rule_base     = RADDR_W'(idx_ff) * RADDR_W'(MAX_RANGES);
   assign range_rd_addr = rule_base + RADDR_W'(rd_slot);
   assign range_wr_addr = rule_base + RADDR_W'(wr_slot);
   assign meta_rd_addr  = req_idx_ext[IDX_W-1:0];
   assign meta_wr_addr  = idx_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_META;
         end
         S_META: begin
            if (!emit) state_in = S_SCAN;
            else if (out_free) state_in = S_IDLE;
         end
         S_SCAN: begin
            if (!issue) state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!emit) state_in = S_MOVE;
            else if (out_free) state_in = S_IDLE;
         end
         S_MOVE: begin
            if (!issue) state_in = S_PLACE;
         end
         S_PLACE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      emit        = 1'b0;
      emit_status = ST_MERGED;
      emit_cnt    = '0;
      emit_s      = '0;
      emit_e      = '0;
      issue       = 1'b0;
      rd_slot     = ptr_ff;
      wr_slot     = '0;
      meta_ctl    = '0;
      range_ctl   = '0;
      meta_wdata  = {w_ff, h_ff, new_cnt};
      range_wdata = {s_ff, e_ff};
      set_valid   = 1'b0;
      case (state_ff)
         S_IDLE: begin
            meta_ctl.rd_en = req_fire;
         end
         S_META: begin
            if (!in_range_ff) begin
               emit        = 1'b1;
               emit_status = ST_MISMATCH;
            end else if (s_ff > e_ff) begin
               emit        = 1'b1;
               emit_status = ST_ORDER;
               emit_cnt    = cur_cnt;
            end else if (!rule_vld) begin
               emit            = 1'b1;
               emit_status     = ST_CREATED;
               emit_cnt        = CNT_W'(1);
               emit_s          = s_ff;
               emit_e          = e_ff;
               meta_wdata      = {w_ff, h_ff, CNT_W'(1)};
               meta_ctl.wr_en  = out_free;
               range_ctl.wr_en = out_free;
               set_valid       = out_free;
            end else if (param_diff) begin
               emit        = 1'b1;
               emit_status = ST_MISMATCH;
               emit_cnt    = cur_cnt;
            end
         end
         S_SCAN: begin
            issue           = (ptr_ff != cnt_ff);
            range_ctl.rd_en = issue;
         end
         S_CHECK: begin
            if (list_full) begin
               emit        = 1'b1;
               emit_status = ST_FULL;
               emit_cnt    = cnt_ff;
            end
         end
         S_MOVE: begin
            // Shift up walks down from the end, shift down walks up: a slot
            // is always read before it is overwritten.
            issue           = move_dn ? (ptr_ff != p_ff) : (ptr_ff != cnt_ff);
            rd_slot         = move_dn ? (ptr_ff - CNT_W'(1)) : ptr_ff;
            range_ctl.rd_en = issue;
            range_ctl.wr_en = rd_vld_ff;
            range_wdata     = range_rdata;
            wr_slot         = src_ff + CNT_W'(1) - k_ff;
         end
         S_PLACE: begin
            emit            = 1'b1;
            emit_status     = ST_MERGED;
            emit_cnt        = new_cnt;
            emit_s          = s_ff;
            emit_e          = e_ff;
            wr_slot         = p_ff;
            meta_ctl.wr_en  = out_free;
            range_ctl.wr_en = out_free;
         end
         default: ;
      endcase
      emit_go = emit && out_free;
   end

   // Datapath next values
   always_comb begin
      idx_in      = idx_ff;
      in_range_in = in_range_ff;
      s_in        = s_ff;
      e_in        = e_ff;
      w_in        = w_ff;
      h_in        = h_ff;
      cnt_in      = cnt_ff;
      k_in        = k_ff;
      p_in        = p_ff;
      ptr_in      = ptr_ff;
      src_in      = rd_slot;
      rd_vld_in   = issue;
      valid_in    = valid_ff;
      if (set_valid) valid_in[idx_ff] = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               idx_in      = req_idx_ext[IDX_W-1:0];
               in_range_in = (int'(req_rule_index) < NUM_RULES);
               s_in        = req_start_bar;
               e_in        = req_end_bar;
               w_in        = req_rule_weight;
               h_in        = req_hand_kind;
            end
         end
         S_META: begin
            cnt_in = meta_cnt;
            ptr_in = '0;
            k_in   = '0;
            p_in   = '0;
         end
         S_SCAN: begin
            if (issue) ptr_in = ptr_ff + CNT_W'(1);
            if (rd_vld_ff) begin
               if (rd_ovl) begin
                  if (rd_s < s_ff) s_in = rd_s;
                  if (rd_e > e_ff) e_in = rd_e;
                  k_in = k_ff + CNT_W'(1);
               end else if (rd_e < s_ff) begin
                  p_in = p_ff + CNT_W'(1);
               end
            end
         end
         S_CHECK: begin
            ptr_in = move_dn ? cnt_ff : (p_ff + k_ff);
         end
         S_MOVE: begin
            if (issue) ptr_in = move_dn ? (ptr_ff - CNT_W'(1)) : (ptr_ff + CNT_W'(1));
         end
         default: ;
      endcase
   end

   // Result register: load on emit, drop once taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_start_in  = rsp_start_ff;
      rsp_end_in    = rsp_end_ff;
      if (emit_go) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = emit_status;
         rsp_count_in  = emit_cnt;
         rsp_start_in  = emit_s;
         rsp_end_in    = emit_e;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      in_range_ff   <= in_range_in;
      s_ff          <= s_in;
      e_ff          <= e_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      cnt_ff        <= cnt_in;
      k_ff          <= k_in;
      p_ff          <= p_in;
      ptr_ff        <= ptr_in;
      src_ff        <= src_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_start_ff  <= rsp_start_in;
      rsp_end_ff    <= rsp_end_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_range_count  = COUNT_OUT_W'(rsp_count_ff);
   assign rsp_merged_start = rsp_start_ff;
   assign rsp_merged_end   = rsp_end_ff;

endmodule

[src/interval_set_insert_merge_unit.sv]
// Interval rule table with insert and merge of bar ranges.
//
// Requests come in on the req_ valid/ready channel: a rule index, an inclusive
// start and end bar, a weight and a hand kind. Each request gives exactly one
// result on the rsp_ valid/ready channel: a status, the rule's range count
// afterwards and, on success, the stored range that now covers the new one.
// Rule parameters live in one RAM and the range lists in a second RAM, both
// with registered read data. A refused request or a new rule is answered
// straight from the parameter read; a full list is answered after the range
// scan. A merge into a rule holding N ranges reads all N ranges, then shifts
// the list tail and writes the merged range. One request is in flight at a
// time; req_ready is high only when the block is idle, from the cycle after
// the result is loaded. The result sits in an output register, so the next
// request is accepted while a result still waits; if the receiver stalls and
// a second result is ready, the block holds it and writes nothing until the
// register frees. Reset clears the rule valid bits and the channels; RAM
// contents need no clearing, as only the contents of valid rules are used.
`include "interval_set_insert_merge_unit_macros.svh"
module interval_set_insert_merge_unit
   import isim_pkg::*;
#(
   parameter int NUM_RULES  = DEF_NUM_RULES,
   parameter int MAX_RANGES = DEF_MAX_RANGES
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [IDX_IN_W-1:0]    req_rule_index,
   input  logic [BAR_BITS-1:0]    req_start_bar,
   input  logic [BAR_BITS-1:0]    req_end_bar,
   input  logic [WEIGHT_W-1:0]    req_rule_weight,
   input  logic [HAND_W-1:0]      req_hand_kind,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [STATUS_W-1:0]    rsp_status,
   output logic [COUNT_OUT_W-1:0] rsp_range_count,
   output logic [BAR_BITS-1:0]    rsp_merged_start,
   output logic [BAR_BITS-1:0]    rsp_merged_end
);

   localparam int IDX_W   = addr_bits(NUM_RULES);
   localparam int CNT_W   = $clog2(MAX_RANGES + 1);
   localparam int META_W  = WEIGHT_W + HAND_W + CNT_W;
   localparam int RDEPTH  = NUM_RULES * MAX_RANGES;
   localparam int RADDR_W = addr_bits(RDEPTH);
   localparam int RANGE_W = 2 * BAR_BITS;

   ram_ctl_type          meta_ctl;
   logic [IDX_W-1:0]     meta_wr_addr, meta_rd_addr;
   logic [META_W-1:0]    meta_wdata, meta_rdata;
   ram_ctl_type          range_ctl;
   logic [RADDR_W-1:0]   range_wr_addr, range_rd_addr;
   logic [RANGE_W-1:0]   range_wdata, range_rdata;

   isim_seq #(
      .NUM_RULES  (NUM_RULES),
      .MAX_RANGES (MAX_RANGES)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rule_index   (req_rule_index),
      .req_start_bar    (req_start_bar),
      .req_end_bar      (req_end_bar),
      .req_rule_weight  (req_rule_weight),
      .req_hand_kind    (req_hand_kind),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_range_count  (rsp_range_count),
      .rsp_merged_start (rsp_merged_start),
      .rsp_merged_end   (rsp_merged_end),
      .meta_ctl         (meta_ctl),
      .meta_wr_addr     (meta_wr_addr),
      .meta_rd_addr     (meta_rd_addr),
      .meta_wdata       (meta_wdata),
      .meta_rdata       (meta_rdata),
      .range_ctl        (range_ctl),
      .range_wr_addr    (range_wr_addr),
      .range_rd_addr    (range_rd_addr),
      .range_wdata      (range_wdata),
      .range_rdata      (range_rdata)
   );

   isim_ram #(
      .DEPTH (NUM_RULES),
      .WIDTH (META_W)
   ) u_meta_ram (
      .clock   (clock),
      .ctl     (meta_ctl),
      .wr_addr (meta_wr_addr),
      .wr_data (meta_wdata),
      .rd_addr (meta_rd_addr),
      .rd_data (meta_rdata)
   );

   isim_ram #(
      .DEPTH (RDEPTH),
      .WIDTH (RANGE_W)
   ) u_range_ram (
      .clock   (clock),
      .ctl     (range_ctl),
      .wr_addr (range_wr_addr),
      .wr_data (range_wdata),
      .rd_addr (range_rd_addr),
      .rd_data (range_rdata)
   );

   `ISIM_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `ISIM_ASSERT_IMPL(a_no_commit_on_accept, clock, reset, meta_ctl.wr_en, !(req_valid && req_ready))
   `ISIM_ASSERT_IMPL(a_commit_before_success, clock, reset, $rose(rsp_valid), $past(meta_ctl.wr_en) || (rsp_status != ST_CREATED && rsp_status != ST_MERGED))
   `ISIM_ASSERT_IMPL(a_count_in_bounds, clock, reset, rsp_valid, int'(rsp_range_count) <= MAX_RANGES)

endmodule

[test/tb_top.sv]
// Self-checking testbench for the interval set insert and merge unit.
module tb_top
   import isim_pkg::*;
();

   typedef struct {
      status_type             status;
      logic [COUNT_OUT_W-1:0] count;
      logic [BAR_BITS-1:0]    lo;
      logic [BAR_BITS-1:0]    hi;
   } outcome_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [IDX_IN_W-1:0]    req_rule_index = '0;
   logic [BAR_BITS-1:0]    req_start_bar = '0;
   logic [BAR_BITS-1:0]    req_end_bar = '0;
   logic [WEIGHT_W-1:0]    req_rule_weight = '0;
   logic [HAND_W-1:0]      req_hand_kind = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [COUNT_OUT_W-1:0] rsp_range_count;
   logic [BAR_BITS-1:0]    rsp_merged_start;
   logic [BAR_BITS-1:0]    rsp_merged_end;

   // Mirror of the rule table.
   bit                     rule_live [DEF_NUM_RULES];
   logic [WEIGHT_W-1:0]    rule_wt   [DEF_NUM_RULES];
   logic [HAND_W-1:0]      rule_hand [DEF_NUM_RULES];
   int                     rule_spans [DEF_NUM_RULES];
   logic [BAR_BITS-1:0]    span_lo [DEF_NUM_RULES][DEF_MAX_RANGES];
   logic [BAR_BITS-1:0]    span_hi [DEF_NUM_RULES][DEF_MAX_RANGES];

   outcome_type            pending_outcomes [$];
   int                     error_count = 0;
   int                     burst_left = 0;
   int                     stall_left = 0;
   int                     stall_pct = 0;
   int                     pattern_cycles = 0;

   interval_set_insert_merge_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_rule_index   (req_rule_index),
      .req_start_bar    (req_start_bar),
      .req_end_bar      (req_end_bar),
      .req_rule_weight  (req_rule_weight),
      .req_hand_kind    (req_hand_kind),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_range_count  (rsp_range_count),
      .rsp_merged_start (rsp_merged_start),
      .rsp_merged_end   (rsp_merged_end)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Apply one add request to the mirror table and return the answer it earns.
   function automatic outcome_type insert_interval(input logic [IDX_IN_W-1:0] idx,
                                                   input logic [BAR_BITS-1:0] s,
                                                   input logic [BAR_BITS-1:0] e,
                                                   input logic [WEIGHT_W-1:0] w,
                                                   input logic [HAND_W-1:0]   h);
      outcome_type         res;
      logic [BAR_BITS-1:0] lo;
      logic [BAR_BITS-1:0] hi;
      logic [BAR_BITS-1:0] rs;
      logic [BAR_BITS-1:0] re;
      logic [BAR_BITS-1:0] new_lo [DEF_MAX_RANGES+1];
      logic [BAR_BITS-1:0] new_hi [DEF_MAX_RANGES+1];
      int                  held;
      int                  n;
      bit                  placed;
      lo = s;
      hi = e;
      n = 0;
      placed = 1'b0;
      res.lo = '0;
      res.hi = '0;
      if (idx >= DEF_NUM_RULES) begin
         res.status = ST_MISMATCH;
         res.count = '0;
         return res;
      end
      held = rule_live[idx] ? rule_spans[idx] : 0;
      res.count = COUNT_OUT_W'(held);
      if (lo > hi) begin
         res.status = ST_ORDER;
         return res;
      end
      if (!rule_live[idx]) begin
         rule_live[idx] = 1'b1;
         rule_wt[idx] = w;
         rule_hand[idx] = h;
         rule_spans[idx] = 1;
         span_lo[idx][0] = lo;
         span_hi[idx][0] = hi;
         res.status = ST_CREATED;
         res.count = COUNT_OUT_W'(1);
         res.lo = lo;
         res.hi = hi;
         return res;
      end
      if (rule_wt[idx] != w || rule_hand[idx] != h) begin
         res.status = ST_MISMATCH;
         return res;
      end
      // Widen the new span over every stored span that overlaps or shares a bar.
      for (int i = 0; i < held; i++) begin
         rs = span_lo[idx][i];
         re = span_hi[idx][i];
         if (re >= lo && rs <= hi) begin
            if (rs < lo) lo = rs;
            if (re > hi) hi = re;
         end
      end
      // Rebuild the sorted list, dropping the absorbed spans.
      for (int i = 0; i < held; i++) begin
         rs = span_lo[idx][i];
         re = span_hi[idx][i];
         if (!(re >= lo && rs <= hi)) begin
            if (!placed && rs > hi) begin
               new_lo[n] = lo;
               new_hi[n] = hi;
               n++;
               placed = 1'b1;
            end
            new_lo[n] = rs;
            new_hi[n] = re;
            n++;
         end
      end
      if (!placed) begin
         new_lo[n] = lo;
         new_hi[n] = hi;
         n++;
      end
      if (n > DEF_MAX_RANGES) begin
         res.status = ST_FULL;
         return res;
      end
      for (int i = 0; i < n; i++) begin
         span_lo[idx][i] = new_lo[i];
         span_hi[idx][i] = new_hi[i];
      end
      rule_spans[idx] = n;
      res.status = ST_MERGED;
      res.count = COUNT_OUT_W'(n);
      res.lo = lo;
      res.hi = hi;
      return res;
   endfunction

   // Send one request; sometimes idle between bursts; record the answer at acceptance.
   task automatic send_request(input logic [IDX_IN_W-1:0] idx,
                               input logic [BAR_BITS-1:0] s,
                               input logic [BAR_BITS-1:0] e,
                               input logic [WEIGHT_W-1:0] w,
                               input logic [HAND_W-1:0]   h);
      int          gap;
      outcome_type answer;
      if (burst_left == 0) begin
         burst_left = int'($urandom_range(1, 20));
         gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_rule_index  <= idx;
      req_start_bar   <= s;
      req_end_bar     <= e;
      req_rule_weight <= w;
      req_hand_kind   <= h;
      req_valid       <= 1'b1;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      answer = insert_interval(idx, s, e, w, h);
      pending_outcomes = {pending_outcomes, answer};
   endtask

   // Receiver: switch between no stalls, light stalls and heavy stalls.
   always @(posedge clock) begin
      if (pattern_cycles == 0) begin
         pattern_cycles <= $urandom_range(50, 300);
         case ($urandom_range(0, 2))
            0: stall_pct <= 0;
            1: stall_pct <= 15;
            default: stall_pct <= 50;
         endcase
      end else begin
         pattern_cycles <= pattern_cycles - 1;
      end
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         stall_left <= $urandom_range(0, 30);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Compare each result transaction with the oldest outstanding answer.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result: status %0d count %0d span %0d..%0d", $time,
                     rsp_status, rsp_range_count, rsp_merged_start, rsp_merged_end);
            error_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_range_count !== want.count) begin
               $display("%0t: range_count expected %0d actual %0d", $time, want.count,
                        rsp_range_count);
               error_count++;
            end
            if (rsp_merged_start !== want.lo) begin
               $display("%0t: merged_start expected %0d actual %0d", $time, want.lo,
                        rsp_merged_start);
               error_count++;
            end
            if (rsp_merged_end !== want.hi) begin
               $display("%0t: merged_end expected %0d actual %0d", $time, want.hi,
                        rsp_merged_end);
               error_count++;
            end
         end
      end
   end

   task automatic test_order_and_create();
      send_request(4'd1, 12'd200, 12'd100, 16'hFFFF, 2'd3);
      send_request(4'd1, 12'd100, 12'd200, 16'hFFFF, 2'd3);
      send_request(4'd1, 12'd4095, 12'd0, 16'hFFFF, 2'd3);
   endtask

   task automatic test_param_mismatch();
      send_request(4'd1, 12'd100, 12'd200, 16'hFFFE, 2'd3);
      send_request(4'd1, 12'd100, 12'd200, 16'hFFFF, 2'd0);
   endtask

   task automatic test_merge_rules();
      // adjacent stays apart, shared bar joins, wide span swallows both
      send_request(4'd1, 12'd201, 12'd300, 16'hFFFF, 2'd3);
      send_request(4'd1, 12'd300, 12'd350, 16'hFFFF, 2'd3);
      send_request(4'd1, 12'd150, 12'd260, 16'hFFFF, 2'd3);
   endtask

   task automatic test_full_list();
      for (int i = 0; i < DEF_MAX_RANGES - 1; i++)
         send_request(4'd2, BAR_BITS'(i * 16), BAR_BITS'(i * 16 + ((i == 0) ? 0 : 2)),
                      16'h0000, 2'd0);
      send_request(4'd2, 12'd4095, 12'd4095, 16'h0000, 2'd0);
      send_request(4'd2, 12'd500, 12'd500, 16'h0000, 2'd0);
      send_request(4'd2, 12'd1, 12'd17, 16'h0000, 2'd0);
      send_request(4'd2, 12'd0, 12'd40, 16'h0000, 2'd0);
   endtask

   task automatic test_random_traffic();
      logic [IDX_IN_W-1:0] idx;
      logic [BAR_BITS-1:0] s;
      logic [BAR_BITS-1:0] e;
      logic [WEIGHT_W-1:0] w;
      logic [HAND_W-1:0]   h;
      int                  region;
      int                  top;
      int                  kind;
      repeat (525) begin
         // Favor a few rules so their lists fill up and merge.
         idx = IDX_IN_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 3)
                                                     : $urandom_range(0, 15));
         w = rule_live[idx] ? rule_wt[idx] : WEIGHT_W'($urandom_range(0, 65535));
         h = rule_live[idx] ? rule_hand[idx] : HAND_W'($urandom_range(0, 3));
         case ($urandom_range(0, 2))
            0: region = 63;
            1: region = 511;
            default: region = 4095;
         endcase
         s = BAR_BITS'($urandom_range(0, region));
         top = int'(s) + int'($urandom_range(0, region / 8));
         e = (top > 4095) ? BAR_BITS'(4095) : BAR_BITS'(top);
         kind = int'($urandom_range(0, 99));
         if (kind < 6) begin
            s = BAR_BITS'($urandom_range(1, 4095));
            e = BAR_BITS'($urandom_range(0, int'(s) - 1));
         end else if (kind < 11) begin
            w = w ^ (WEIGHT_W'(1) << $urandom_range(0, 15));
         end else if (kind < 15) begin
            h = h + 2'd1;
         end
         send_request(idx, s, e, w, h);
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_order_and_create();
      test_param_mismatch();
      test_merge_rules();
      test_full_list();
      test_random_traffic();
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0 && pending_outcomes.size() == 0)
         $display("interval_set_insert_merge_unit test passed");
      else
         $display("interval_set_insert_merge_unit test failed");
      $finish;
   end

   initial begin
      #20000000;
      $display("interval_set_insert_merge_unit test failed");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/isim_pkg.sv
src/isim_ram.sv
src/isim_seq.sv
src/interval_set_insert_merge_unit.sv
test/tb_top.sv
